FILE: hw/rtl/dq_pkg.sv
// Shared constants and codes for the double-ended queue.
package dq_pkg;

    localparam int DQ_DEPTH      = 16;
    localparam int DQ_WORD_WIDTH = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [2:0] ACT_PEEK_BACK  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

FILE: hw/rtl/double_ended_queue_core.sv
// Bounded double-ended queue of signed words kept in a circular buffer RAM.
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_action, i_element
//  result    out        o_valid / i_ready   o_read_word, o_status, o_fill_level, o_is_empty
//
// At the request transfer the indices and count update and the RAM access is issued;
// the RAM registers the read word on that same edge and the result register loads
// when the middle stage moves on, after which o_valid rises.
// Sustained rate is one item per cycle while the result is not stalled, set by the single RAM port.
// Reset clears the indices, the count and the pipeline valids; the RAM is not cleared.
// A stalled result holds the middle stage, which in turn holds off new requests.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [2:0]                      i_action,
    input  logic signed [DQ_WORD_WIDTH-1:0] i_element,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [DQ_WORD_WIDTH-1:0] o_read_word,
    output logic [1:0]                      o_status,
    output logic [CW-1:0]                   o_fill_level,
    output logic                            o_is_empty
);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    logic          r_s1_valid;
    logic          r_s1_rd, n_s1_rd;
    logic [1:0]    r_s1_status, n_s1_status;
    logic [CW-1:0] r_s1_count;

    logic                     r_out_valid;
    logic [DQ_WORD_WIDTH-1:0] r_out_word;
    logic [1:0]               r_out_status;
    logic [CW-1:0]            r_out_count;

    logic                     in_xfer, s1_move;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_addr;
    logic [DQ_WORD_WIDTH-1:0] ram_rdata;
    logic                     q_empty, q_full;
    logic [AW-1:0]            head_inc, head_dec, tail_inc, tail_dec;

    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign in_xfer = i_valid && o_ready;

    assign q_empty = (r_count == '0);
    assign q_full  = (r_count == CW'(DEPTH));

    // indices wrap at DEPTH, which need not be a power of two
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign tail_inc = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
    assign tail_dec = (r_tail == '0) ? AW'(DEPTH - 1) : r_tail - AW'(1);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_s1_rd     = 1'b0;
        n_s1_status = ST_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = r_head;
        case (i_action)
            ACT_PUSH_FRONT: begin
                if (q_full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    ram_we   = in_xfer;
                    ram_addr = head_dec;
                    n_head   = head_dec;
                    n_count  = r_count + CW'(1);
                end
            end
            ACT_PUSH_BACK: begin
                if (q_full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    ram_we   = in_xfer;
                    ram_addr = r_tail;
                    n_tail   = tail_inc;
                    n_count  = r_count + CW'(1);
                end
            end
            ACT_POP_FRONT, ACT_PEEK_FRONT: begin
                if (q_empty) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    ram_re   = in_xfer;
                    ram_addr = r_head;
                    n_s1_rd  = 1'b1;
                    if (i_action == ACT_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            ACT_POP_BACK, ACT_PEEK_BACK: begin
                if (q_empty) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    ram_re   = in_xfer;
                    ram_addr = tail_dec;
                    n_s1_rd  = 1'b1;
                    if (i_action == ACT_POP_BACK) begin
                        n_tail  = tail_dec;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                // unused codes leave the queue untouched
            end
        endcase
    end

    dq_ram #(
        .WIDTH (DQ_WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_element),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_rd     <= n_s1_rd;
            r_s1_status <= n_s1_status;
            r_s1_count  <= n_count;
        end
        if (s1_move) begin
            r_out_word   <= r_s1_rd ? ram_rdata : '0;
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_word  = r_out_word;
    assign o_status     = r_out_status;
    assign o_fill_level = r_out_count;
    assign o_is_empty   = (r_out_count == '0);

endmodule

FILE: hw/rtl/dq_ram.sv
// Generic single-port RAM with registered read data.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds while no new read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
